// ===== sv/unique_id_and_slot_allocator_core_assert.svh =====
// Assertion macros used by the allocator controller.
`ifndef UNIQUE_ID_AND_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define UNIQUE_ID_AND_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UISA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UISA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/uisa_pkg.sv =====
package uisa_pkg;

	// Fixed widths of the stream fields.
	localparam int SLOT_FW   = 6;
	localparam int NEW_ID_FW = 31;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;
	localparam int M_PAD_W   = M_TDATA_W - SLOT_FW - NEW_ID_FW;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} uisa_state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic flush;  // drop all search beats in flight
		logic set;    // occupy the addressed slot with the write identifier
		logic clr;    // free the addressed slot
	} uisa_cmd_t;

endpackage

// ===== sv/unique_id_and_slot_allocator_core.sv =====
// Allocate: candidate identifiers walk the slot cell chain one cell per cycle, and each
// identifier collision (at most SLOT_COUNT - 1) moves the search on to the next candidate.
// Release: the result is posted without a search. One request is in work at a time: the next
// is taken once the previous result has moved into the output register, even while it
// still waits there.
// Reset (arst_n low, asynchronous): only slot 0 used, identifiers and counter zero, no result.
module unique_id_and_slot_allocator_core import uisa_pkg::*; #(
	parameter int SLOT_COUNT = 64,
	parameter int ID_BITS    = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [5:0] release_slot
	input  logic                 s_tuser,  // [0] kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [5:0] slot, [36:6] new_id
	output logic                 m_tuser   // [0] status
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	logic          w_v     [SLOT_COUNT];
	logic          w_hit   [SLOT_COUNT];
	logic          w_found [SLOT_COUNT];
	logic [ID_BITS-1:0] w_id [SLOT_COUNT];
	logic [SW-1:0] w_fidx  [SLOT_COUNT];

	uisa_cmd_t            cmd;
	logic [SW-1:0]        wr_idx;
	logic [ID_BITS-1:0]   wr_id;
	logic                 inj_v;
	logic [ID_BITS-1:0]   inj_id;
	logic                 res_valid;
	logic                 res_ready;
	logic                 res_status;
	logic [SLOT_FW-1:0]   res_slot;
	logic [NEW_ID_FW-1:0] res_id;

	logic                 m_valid_q;
	logic                 m_status_q;
	logic [SLOT_FW-1:0]   m_slot_q;
	logic [NEW_ID_FW-1:0] m_id_q;

	uisa_ctrl #(
		.SLOT_COUNT(SLOT_COUNT),
		.IB        (ID_BITS),
		.SW        (SW),
		.CW        (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_rel    (s_tdata[SLOT_FW-1:0]),
		.inj_v     (inj_v),
		.inj_id    (inj_id),
		.tail_v    (w_v[SLOT_COUNT-1]),
		.tail_hit  (w_hit[SLOT_COUNT-1]),
		.tail_found(w_found[SLOT_COUNT-1]),
		.tail_id   (w_id[SLOT_COUNT-1]),
		.tail_fidx (w_fidx[SLOT_COUNT-1]),
		.cmd       (cmd),
		.wr_idx    (wr_idx),
		.wr_id     (wr_id),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_status(res_status),
		.res_slot  (res_slot),
		.res_id    (res_id)
	);

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			uisa_cell #(
				.IB (ID_BITS),
				.SW (SW),
				.IDX(i)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.wr_idx   (wr_idx),
				.wr_id    (wr_id),
				.in_v     (inj_v),
				.in_hit   (1'b0),
				.in_found (1'b0),
				.in_id    (inj_id),
				.in_fidx  ('0),
				.out_v    (w_v[i]),
				.out_hit  (w_hit[i]),
				.out_found(w_found[i]),
				.out_id   (w_id[i]),
				.out_fidx (w_fidx[i])
			);
		end else begin : g_body
			uisa_cell #(
				.IB (ID_BITS),
				.SW (SW),
				.IDX(i)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.wr_idx   (wr_idx),
				.wr_id    (wr_id),
				.in_v     (w_v[i-1]),
				.in_hit   (w_hit[i-1]),
				.in_found (w_found[i-1]),
				.in_id    (w_id[i-1]),
				.in_fidx  (w_fidx[i-1]),
				.out_v    (w_v[i]),
				.out_hit  (w_hit[i]),
				.out_found(w_found[i]),
				.out_id   (w_id[i]),
				.out_fidx (w_fidx[i])
			);
		end
	end

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_status_q <= res_status;
			m_slot_q   <= res_slot;
			m_id_q     <= res_id;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_id_q, m_slot_q};

endmodule

// ===== sv/uisa_cell.sv =====
module uisa_cell import uisa_pkg::*; #(
	parameter int IB  = 31,
	parameter int SW  = 6,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  uisa_cmd_t     cmd,
	input  logic [SW-1:0] wr_idx,
	input  logic [IB-1:0] wr_id,
	input  logic          in_v,
	input  logic          in_hit,
	input  logic          in_found,
	input  logic [IB-1:0] in_id,
	input  logic [SW-1:0] in_fidx,
	output logic          out_v,
	output logic          out_hit,
	output logic          out_found,
	output logic [IB-1:0] out_id,
	output logic [SW-1:0] out_fidx
);

	logic          used_q;
	logic [IB-1:0] ident_q;
	logic          v_q;
	logic          hit_q;
	logic          found_q;
	logic [IB-1:0] id_q;
	logic [SW-1:0] fidx_q;
	logic          wr_match;

	assign wr_match = (wr_idx == SW'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= (IDX == 0);
			ident_q <= '0;
		end else if (cmd.set && wr_match) begin
			used_q  <= 1'b1;
			ident_q <= wr_id;
		end else if (cmd.clr && wr_match) begin
			used_q  <= 1'b0;
			ident_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_v && !cmd.flush;
		end
	end

	// Each beat picks up a collision against this slot and the first free slot seen so far.
	always_ff @(posedge clk) begin
		hit_q   <= in_hit || (used_q && (ident_q == in_id));
		found_q <= in_found || !used_q;
		id_q    <= in_id;
		fidx_q  <= in_found ? in_fidx : SW'(IDX);
	end

	assign out_v     = v_q;
	assign out_hit   = hit_q;
	assign out_found = found_q;
	assign out_id    = id_q;
	assign out_fidx  = fidx_q;

endmodule

// ===== sv/uisa_ctrl.sv =====
`include "unique_id_and_slot_allocator_core_assert.svh"

module uisa_ctrl import uisa_pkg::*; #(
	parameter int SLOT_COUNT = 64,
	parameter int IB         = 31,
	parameter int SW         = 6,
	parameter int CW         = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_kind,
	input  logic [SLOT_FW-1:0]   in_rel,
	output logic                 inj_v,
	output logic [IB-1:0]        inj_id,
	input  logic                 tail_v,
	input  logic                 tail_hit,
	input  logic                 tail_found,
	input  logic [IB-1:0]        tail_id,
	input  logic [SW-1:0]        tail_fidx,
	output uisa_cmd_t            cmd,
	output logic [SW-1:0]        wr_idx,
	output logic [IB-1:0]        wr_id,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 res_status,
	output logic [SLOT_FW-1:0]   res_slot,
	output logic [NEW_ID_FW-1:0] res_id
);

	uisa_state_t          state_q, state_d;
	logic [IB-1:0]        id_counter_q;
	logic [IB-1:0]        cand_q;
	logic [CW-1:0]        inj_cnt_q;
	logic [CW-1:0]        tail_cnt_q;
	logic                 res_status_q;
	logic [SLOT_FW-1:0]   res_slot_q;
	logic [NEW_ID_FW-1:0] res_id_q;
	logic                 accept;
	logic                 rel_ok;
	logic                 decide;

	function automatic logic [IB-1:0] id_advance(input logic [IB-1:0] c);
		id_advance = (c == {IB{1'b1}}) ? IB'(1) : c + IB'(1);
	endfunction

	assign accept = in_valid && in_ready;
	assign rel_ok = (in_rel != '0) && (32'(in_rel) < 32'(SLOT_COUNT));
	// A search ends at the first candidate that no used slot holds, or after the last candidate.
	assign decide = (state_q == ST_SEARCH) && tail_v &&
		(!tail_hit || (tail_cnt_q == CW'(SLOT_COUNT - 1)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_kind == KIND_ALLOC) ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (decide) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		inj_v     = (state_q == ST_SEARCH) && (inj_cnt_q < CW'(SLOT_COUNT));
		inj_id    = cand_q;
		res_valid = (state_q == ST_DONE);
		cmd.flush = decide;
		cmd.set   = decide && !tail_hit && tail_found;
		cmd.clr   = accept && (in_kind == KIND_RELEASE) && rel_ok;
		wr_idx    = cmd.clr ? SW'(in_rel) : tail_fidx;
		wr_id     = tail_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			id_counter_q <= '0;
			cand_q       <= '0;
			inj_cnt_q    <= '0;
			tail_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && (in_kind == KIND_ALLOC)) begin
				cand_q     <= id_advance(id_counter_q);
				inj_cnt_q  <= '0;
				tail_cnt_q <= '0;
			end else begin
				if (inj_v) begin
					cand_q    <= id_advance(cand_q);
					inj_cnt_q <= inj_cnt_q + CW'(1);
				end
				if (tail_v) begin
					tail_cnt_q <= tail_cnt_q + CW'(1);
				end
			end
			if (decide) begin
				id_counter_q <= tail_id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= STATUS_OK;
			res_slot_q   <= '0;
			res_id_q     <= '0;
		end else if (decide) begin
			if (cmd.set) begin
				res_status_q <= STATUS_OK;
				res_slot_q   <= SLOT_FW'(tail_fidx);
				res_id_q     <= NEW_ID_FW'(tail_id);
			end else begin
				res_status_q <= STATUS_FULL;
				res_slot_q   <= '0;
				res_id_q     <= '0;
			end
		end
	end

	assign res_status = res_status_q;
	assign res_slot   = res_slot_q;
	assign res_id     = res_id_q;

	`UISA_ASSERT_NOW(a_tail_only_in_search, clk, arst_n, state_q != ST_SEARCH, !tail_v, "search beat outside a search")
	`UISA_ASSERT_NEXT(a_decide_to_done, clk, arst_n, decide, state_q == ST_DONE, "decision did not post a result")
	`UISA_ASSERT_NOW(a_count_bounds, clk, arst_n, state_q == ST_SEARCH, (inj_cnt_q <= CW'(SLOT_COUNT)) && (tail_cnt_q <= inj_cnt_q), "search counters out of range")

endmodule

// ===== dv/unique_id_and_slot_allocator_core_tb.sv =====
`timescale 1ns / 100ps

module unique_id_and_slot_allocator_core_tb import uisa_pkg::*;;

	localparam int SLOTS = 64;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
	localparam int SEGMENT_ITEMS = 50;
	localparam int RANDOM_SEGMENTS = 17;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic                 status;
		logic [SLOT_FW-1:0]   slot;
		logic [NEW_ID_FW-1:0] new_id;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = KIND_ALLOC;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	// Predicted slot table and identifier counter.
	bit                   occupied [SLOTS];
	logic [NEW_ID_FW-1:0] owner_id [SLOTS];
	logic [NEW_ID_FW-1:0] id_ctr;
	grant_t               grant_q[$];

	int     src_gap_max = 8;
	int     snk_gap_max = 8;
	bit     hold_req = 1'b0;
	int     errors = 0;
	longint cycles = 0;

	unique_id_and_slot_allocator_core #(
		.SLOT_COUNT(SLOTS),
		.ID_BITS(NEW_ID_FW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic grant_t predict_grant(logic kind, logic [SLOT_FW-1:0] target);
		grant_t g;
		bit clash;
		int tries;
		g = '0;
		g.status = STATUS_OK;
		if (kind == KIND_RELEASE) begin
			// Slot 0 is reserved, so freeing it is ignored.
			if (target != 0) begin
				occupied[target] = 1'b0;
				owner_id[target] = '0;
			end
			return g;
		end
		tries = 0;
		do begin
			id_ctr = (id_ctr == '1) ? NEW_ID_FW'(1) : id_ctr + 1'b1;
			tries++;
			clash = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				if (occupied[i] && owner_id[i] == id_ctr)
					clash = 1'b1;
		end while (clash && tries < SLOTS);
		g.status = STATUS_FULL;
		if (clash)
			return g;
		for (int i = 1; i < SLOTS; i++) begin
			if (!occupied[i]) begin
				occupied[i] = 1'b1;
				owner_id[i] = id_ctr;
				g.status = STATUS_OK;
				g.slot = SLOT_FW'(i);
				g.new_id = id_ctr;
				return g;
			end
		end
		return g;
	endfunction

	function automatic logic [SLOT_FW-1:0] pick_busy_slot();
		int busy[$];
		for (int i = 1; i < SLOTS; i++)
			if (occupied[i])
				busy.push_back(i);
		if (busy.size() == 0)
			return SLOT_FW'($urandom);
		return SLOT_FW'(busy[$urandom_range(0, busy.size() - 1)]);
	endfunction

	function automatic void note_failure(string what, grant_t want, grant_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected status=%0d slot=%0d id=%0d, got status=%0d slot=%0d id=%0d",
				$time, what, want.status, want.slot, want.new_id,
				got.status, got.slot, got.new_id);
	endfunction

	// Offers one beat and records its prediction once the block takes it.
	task automatic send_request(input logic kind, input logic [SLOT_FW-1:0] target);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(S_TDATA_W - SLOT_FW){1'b0}}, target};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		grant_q.push_back(predict_grant(kind, target));
	endtask

	task automatic test_directed();
		send_request(KIND_RELEASE, SLOT_FW'(0));
		send_request(KIND_RELEASE, SLOT_FW'(63));
		send_request(KIND_RELEASE, SLOT_FW'(1));
		repeat (4) send_request(KIND_ALLOC, SLOT_FW'($urandom));
		send_request(KIND_RELEASE, SLOT_FW'(2));
		send_request(KIND_RELEASE, SLOT_FW'(2));
		// The freed slot must be handed out again before any higher one.
		send_request(KIND_ALLOC, SLOT_FW'(63));
		send_request(KIND_ALLOC, SLOT_FW'(0));
		send_request(KIND_RELEASE, SLOT_FW'(6'h2a));
		send_request(KIND_RELEASE, SLOT_FW'(6'h15));
		send_request(KIND_RELEASE, SLOT_FW'(0));
		send_request(KIND_RELEASE, SLOT_FW'(1));
		send_request(KIND_ALLOC, SLOT_FW'(6'h15));
		send_request(KIND_RELEASE, SLOT_FW'(4));
		send_request(KIND_ALLOC, SLOT_FW'(6'h2a));
	endtask

	task automatic test_table_full();
		int free_slots;
		free_slots = 0;
		for (int i = 1; i < SLOTS; i++)
			if (!occupied[i])
				free_slots++;
		// The last three allocations find no slot but still move the counter.
		repeat (free_slots + 3) send_request(KIND_ALLOC, SLOT_FW'($urandom));
		repeat (6) send_request(KIND_RELEASE, pick_busy_slot());
		repeat (8) send_request(KIND_ALLOC, SLOT_FW'($urandom));
		for (int i = SLOTS - 1; i >= 1; i--)
			send_request(KIND_RELEASE, SLOT_FW'(i));
	endtask

	task automatic test_backpressure();
		src_gap_max = 0;
		hold_req = 1'b1;
		for (int n = 0; n < 24; n++) begin
			if (n % 3 == 2)
				send_request(KIND_RELEASE, pick_busy_slot());
			else
				send_request(KIND_ALLOC, SLOT_FW'($urandom));
		end
		src_gap_max = 8;
	endtask

	task automatic test_random();
		int alloc_pct;
		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			case ($urandom_range(0, 3))
				0: alloc_pct = 20;
				1: alloc_pct = 50;
				2: alloc_pct = 80;
				default: alloc_pct = 97;
			endcase
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			repeat (SEGMENT_ITEMS) begin
				if ($urandom_range(1, 100) <= alloc_pct)
					send_request(KIND_ALLOC, SLOT_FW'($urandom));
				else if ($urandom_range(0, 4) != 0)
					send_request(KIND_RELEASE, pick_busy_slot());
				else
					send_request(KIND_RELEASE, SLOT_FW'($urandom));
			end
		end
		src_gap_max = 8;
		snk_gap_max = 8;
	endtask

	// Receives result beats and checks each against the oldest prediction.
	initial begin : result_sink
		int gap;
		grant_t got;
		grant_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = $urandom_range(0, snk_gap_max);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.status = m_tuser;
			got.slot = m_tdata[SLOT_FW-1:0];
			got.new_id = m_tdata[SLOT_FW +: NEW_ID_FW];
			if (grant_q.size() == 0) begin
				note_failure("unexpected result beat", '0, got);
			end else begin
				want = grant_q.pop_front();
				if (got.status !== want.status || got.slot !== want.slot
						|| got.new_id !== want.new_id)
					note_failure("result mismatch", want, got);
			end
		end
	end

	initial begin : stimulus
		for (int i = 0; i < SLOTS; i++) begin
			occupied[i] = (i == 0);
			owner_id[i] = '0;
		end
		id_ctr = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/uisa_pkg.sv
sv/uisa_cell.sv
sv/uisa_ctrl.sv
sv/unique_id_and_slot_allocator_core.sv
dv/unique_id_and_slot_allocator_core_tb.sv
